/* rtl/core/three_wheel_omni_mixer_core_macros.svh */
// Assertion helpers for the omni mixer core.
// Each helper expects clk and arst_n in scope.
`ifndef THREE_WHEEL_OMNI_MIXER_CORE_MACROS_SVH
`define THREE_WHEEL_OMNI_MIXER_CORE_MACROS_SVH

`ifndef SYNTH
// Check the consequent in the same cycle as the antecedent
`define TWOM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("three_wheel_omni_mixer_core: assertion failed");
// Check the consequent in the cycle after the antecedent
`define TWOM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("three_wheel_omni_mixer_core: assertion failed");
`else
`define TWOM_ASSERT_IMPL(lbl, ante, cons)
`define TWOM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/twom_pkg.sv */
`default_nettype none

package twom_pkg;

	localparam int NUM_WHEELS = 3;
	localparam int ANGLE_W    = 9;
	localparam int IDX_W      = 7;
	localparam int MAG_W      = 17;
	localparam int FRAC_W     = 16;
	localparam int SPEED_W    = 8;
	localparam int DUTY_W     = 8;

	localparam int WHEEL_A = 0;
	localparam int WHEEL_B = 1;
	localparam int WHEEL_C = 2;

	localparam logic [ANGLE_W-1:0] FULL_TURN     = 9'd360;
	localparam logic [ANGLE_W-1:0] HALF_TURN     = 9'd180;
	localparam logic [ANGLE_W-1:0] QUARTER_TURN  = 9'd90;
	localparam logic [ANGLE_W-1:0] THREE_QUARTER = 9'd270;
	localparam logic [IDX_W-1:0]   IDX_MAX       = 7'd90;

	// Mounting angles of the wheels, wheel A in the low slot
	localparam logic [NUM_WHEELS-1:0][ANGLE_W-1:0] WHEEL_DEG = {9'd300, 9'd180, 9'd60};

	// Command after heading wrap
	typedef struct packed {
		logic [ANGLE_W-1:0] heading;
		logic [SPEED_W-1:0] speed;
	} twom_cmd_t;

	// Quarter-wave table index and sign per wheel
	typedef struct packed {
		logic [NUM_WHEELS-1:0][IDX_W-1:0] idx;
		logic [NUM_WHEELS-1:0]            neg;
		logic [SPEED_W-1:0]               speed;
	} twom_ang_t;

	// Sine magnitude and direction per wheel
	typedef struct packed {
		logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
		logic [NUM_WHEELS-1:0]            fwd;
		logic [SPEED_W-1:0]               speed;
	} twom_mag_t;

	// Final drive word
	typedef struct packed {
		logic [NUM_WHEELS-1:0][DUTY_W-1:0] duty;
		logic [NUM_WHEELS-1:0]             fwd;
	} twom_res_t;

	// Quarter-wave sine, round(sin(k deg) * 65536) for k = 0..90
	function automatic logic [MAG_W-1:0] sin_q16(input logic [IDX_W-1:0] idx);
		logic [MAG_W-1:0] v;
		case (idx)
			7'd0:  v = 17'd0;
			7'd1:  v = 17'd1144;
			7'd2:  v = 17'd2287;
			7'd3:  v = 17'd3430;
			7'd4:  v = 17'd4572;
			7'd5:  v = 17'd5712;
			7'd6:  v = 17'd6850;
			7'd7:  v = 17'd7987;
			7'd8:  v = 17'd9121;
			7'd9:  v = 17'd10252;
			7'd10: v = 17'd11380;
			7'd11: v = 17'd12505;
			7'd12: v = 17'd13626;
			7'd13: v = 17'd14742;
			7'd14: v = 17'd15855;
			7'd15: v = 17'd16962;
			7'd16: v = 17'd18064;
			7'd17: v = 17'd19161;
			7'd18: v = 17'd20252;
			7'd19: v = 17'd21336;
			7'd20: v = 17'd22415;
			7'd21: v = 17'd23486;
			7'd22: v = 17'd24550;
			7'd23: v = 17'd25607;
			7'd24: v = 17'd26656;
			7'd25: v = 17'd27697;
			7'd26: v = 17'd28729;
			7'd27: v = 17'd29753;
			7'd28: v = 17'd30767;
			7'd29: v = 17'd31772;
			7'd30: v = 17'd32768;
			7'd31: v = 17'd33754;
			7'd32: v = 17'd34729;
			7'd33: v = 17'd35693;
			7'd34: v = 17'd36647;
			7'd35: v = 17'd37590;
			7'd36: v = 17'd38521;
			7'd37: v = 17'd39441;
			7'd38: v = 17'd40348;
			7'd39: v = 17'd41243;
			7'd40: v = 17'd42126;
			7'd41: v = 17'd42995;
			7'd42: v = 17'd43852;
			7'd43: v = 17'd44695;
			7'd44: v = 17'd45525;
			7'd45: v = 17'd46341;
			7'd46: v = 17'd47143;
			7'd47: v = 17'd47930;
			7'd48: v = 17'd48703;
			7'd49: v = 17'd49461;
			7'd50: v = 17'd50203;
			7'd51: v = 17'd50931;
			7'd52: v = 17'd51643;
			7'd53: v = 17'd52339;
			7'd54: v = 17'd53020;
			7'd55: v = 17'd53684;
			7'd56: v = 17'd54332;
			7'd57: v = 17'd54963;
			7'd58: v = 17'd55578;
			7'd59: v = 17'd56175;
			7'd60: v = 17'd56756;
			7'd61: v = 17'd57319;
			7'd62: v = 17'd57865;
			7'd63: v = 17'd58393;
			7'd64: v = 17'd58903;
			7'd65: v = 17'd59396;
			7'd66: v = 17'd59870;
			7'd67: v = 17'd60326;
			7'd68: v = 17'd60764;
			7'd69: v = 17'd61183;
			7'd70: v = 17'd61584;
			7'd71: v = 17'd61966;
			7'd72: v = 17'd62328;
			7'd73: v = 17'd62672;
			7'd74: v = 17'd62997;
			7'd75: v = 17'd63303;
			7'd76: v = 17'd63589;
			7'd77: v = 17'd63856;
			7'd78: v = 17'd64104;
			7'd79: v = 17'd64332;
			7'd80: v = 17'd64540;
			7'd81: v = 17'd64729;
			7'd82: v = 17'd64898;
			7'd83: v = 17'd65048;
			7'd84: v = 17'd65177;
			7'd85: v = 17'd65287;
			7'd86: v = 17'd65376;
			7'd87: v = 17'd65446;
			7'd88: v = 17'd65496;
			7'd89: v = 17'd65526;
			7'd90: v = 17'd65536;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/twom_if.sv */
`default_nettype none

// Command channel: heading and speed
interface twom_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [twom_pkg::ANGLE_W-1:0] heading_deg;
	logic [twom_pkg::SPEED_W-1:0] speed;

	modport source (output valid, output heading_deg, output speed, input ready);
	modport sink   (input valid, input heading_deg, input speed, output ready);
endinterface

// Drive channel: duty and direction for each wheel
interface twom_drive_if;
	logic                        valid;
	logic                        ready;
	logic [twom_pkg::DUTY_W-1:0] wheel_a_duty;
	logic                        wheel_a_forward;
	logic [twom_pkg::DUTY_W-1:0] wheel_b_duty;
	logic                        wheel_b_forward;
	logic [twom_pkg::DUTY_W-1:0] wheel_c_duty;
	logic                        wheel_c_forward;

	modport source (
		output valid,
		output wheel_a_duty, output wheel_a_forward,
		output wheel_b_duty, output wheel_b_forward,
		output wheel_c_duty, output wheel_c_forward,
		input  ready
	);
	modport sink (
		input  valid,
		input  wheel_a_duty, input wheel_a_forward,
		input  wheel_b_duty, input wheel_b_forward,
		input  wheel_c_duty, input wheel_c_forward,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/core/three_wheel_omni_mixer_core.sv */
// Three-wheel omni drive mixer.
// cmd: one word per command, heading_deg in whole degrees (360..511 wrap by
//   one turn) and speed as 8-bit duty. A word is taken when valid and ready.
// drv: one word per command with duty and forward bit for the wheels at
//   60 (A), 180 (B) and 300 (C) degrees, in command order.
// Four register stages: heading wrap, angle fold, sine table read, speed
//   scale; a command passes through each of them in that order before its
//   result shows on drv. One command is taken every cycle while drv keeps up.
// Each stage holds its own valid bit and loads when empty or when its word
//   moves on, so empty stages keep cmd.ready high while drv stalls; cmd.ready
//   drops only once all four stages hold words.
// Reset clears every valid bit; payload registers are not reset.
`default_nettype none
`include "three_wheel_omni_mixer_core_macros.svh"

module three_wheel_omni_mixer_core (
	input  wire logic clk,
	input  wire logic arst_n,
	twom_cmd_if.sink    cmd,
	twom_drive_if.source drv
);
	import twom_pkg::*;

	logic      ang_valid;
	logic      ang_ready;
	twom_ang_t ang_data;
	logic      mag_valid;
	logic      mag_ready;
	twom_mag_t mag_data;
	twom_res_t res_data;

	twom_angle u_angle (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cmd.valid),
		.up_ready (cmd.ready),
		.heading  (cmd.heading_deg),
		.speed    (cmd.speed),
		.dn_valid (ang_valid),
		.dn_ready (ang_ready),
		.dn_data  (ang_data)
	);

	twom_sine u_sine (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (ang_valid),
		.up_ready (ang_ready),
		.up_data  (ang_data),
		.dn_valid (mag_valid),
		.dn_ready (mag_ready),
		.dn_data  (mag_data)
	);

	twom_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mag_valid),
		.up_ready (mag_ready),
		.up_data  (mag_data),
		.dn_valid (drv.valid),
		.dn_ready (drv.ready),
		.dn_data  (res_data)
	);

	// Spread the result word over the drive channel
	assign drv.wheel_a_duty    = res_data.duty[WHEEL_A];
	assign drv.wheel_a_forward = res_data.fwd[WHEEL_A];
	assign drv.wheel_b_duty    = res_data.duty[WHEEL_B];
	assign drv.wheel_b_forward = res_data.fwd[WHEEL_B];
	assign drv.wheel_c_duty    = res_data.duty[WHEEL_C];
	assign drv.wheel_c_forward = res_data.fwd[WHEEL_C];

	// Back-pressure reaches the command side only with the pipe full
	`TWOM_ASSERT_IMPL(a_full_when_blocked, !cmd.ready,
		ang_valid && mag_valid && drv.valid && !drv.ready)
	// Folded angles stay within the quarter-wave table
	`TWOM_ASSERT_IMPL(a_idx_in_table, ang_valid,
		(ang_data.idx[0] <= IDX_MAX) && (ang_data.idx[1] <= IDX_MAX) &&
		(ang_data.idx[2] <= IDX_MAX))
	// A backward wheel never has a zero sine
	`TWOM_ASSERT_IMPL(a_backward_nonzero, mag_valid,
		(mag_data.fwd[0] || (mag_data.mag[0] != '0)) &&
		(mag_data.fwd[1] || (mag_data.mag[1] != '0)) &&
		(mag_data.fwd[2] || (mag_data.mag[2] != '0)))
	// A word handed to the sine stage shows up there next cycle
	`TWOM_ASSERT_NEXT(a_sine_advance, ang_valid && ang_ready, mag_valid)

endmodule

`default_nettype wire

/* rtl/core/twom_angle.sv */
`default_nettype none

// Stages 1 and 2: wrap heading, then reduce each wheel angle to a table index and sign
module twom_angle (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         up_valid,
	output logic                              up_ready,
	input  wire logic [twom_pkg::ANGLE_W-1:0] heading,
	input  wire logic [twom_pkg::SPEED_W-1:0] speed,
	output logic                              dn_valid,
	input  wire logic                         dn_ready,
	output twom_pkg::twom_ang_t               dn_data
);
	import twom_pkg::*;

	logic       valid_s1;
	twom_cmd_t  cmd_s1;
	logic       valid_s2;
	twom_ang_t  ang_s2;
	logic       ready_s1;
	logic       ready_s2;

	logic [ANGLE_W-1:0] heading_wrap;
	logic [ANGLE_W:0]   turn [NUM_WHEELS];
	logic [ANGLE_W-1:0] ang  [NUM_WHEELS];
	logic [ANGLE_W-1:0] red  [NUM_WHEELS];
	twom_ang_t          ang_next;

	// A stage takes a word when it is empty or its word moves on
	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	// Drop one full turn from headings past 359
	assign heading_wrap = (heading >= FULL_TURN) ? (heading - FULL_TURN) : heading;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			cmd_s1.heading <= heading_wrap;
			cmd_s1.speed   <= speed;
		end
	end

	// Fold wheel minus heading into one quadrant of the table
	always_comb begin
		ang_next       = '0;
		ang_next.speed = cmd_s1.speed;
		for (int w = 0; w < NUM_WHEELS; w++) begin
			turn[w] = {1'b0, WHEEL_DEG[w]} + {1'b0, FULL_TURN} - {1'b0, cmd_s1.heading};
			if (turn[w] >= {1'b0, FULL_TURN}) begin
				turn[w] = turn[w] - {1'b0, FULL_TURN};
			end
			ang[w] = turn[w][ANGLE_W-1:0];
			case (ang[w]) inside
				[9'd0:QUARTER_TURN]: begin
					red[w]          = ang[w];
					ang_next.neg[w] = 1'b0;
				end
				[QUARTER_TURN+9'd1:HALF_TURN]: begin
					red[w]          = HALF_TURN - ang[w];
					ang_next.neg[w] = 1'b0;
				end
				[HALF_TURN+9'd1:THREE_QUARTER]: begin
					red[w]          = ang[w] - HALF_TURN;
					ang_next.neg[w] = 1'b1;
				end
				default: begin
					red[w]          = FULL_TURN - ang[w];
					ang_next.neg[w] = 1'b1;
				end
			endcase
			ang_next.idx[w] = red[w][IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			ang_s2 <= ang_next;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = ang_s2;

endmodule

`default_nettype wire

/* rtl/core/twom_sine.sv */
`default_nettype none

// Stage 3: read the quarter-wave table and settle the direction bit
module twom_sine (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 up_valid,
	output logic                      up_ready,
	input  wire twom_pkg::twom_ang_t  up_data,
	output logic                      dn_valid,
	input  wire logic                 dn_ready,
	output twom_pkg::twom_mag_t       dn_data
);
	import twom_pkg::*;

	logic      valid_s3;
	twom_mag_t mag_s3;
	twom_mag_t mag_next;

	assign up_ready = !valid_s3 || dn_ready;

	// Exact zeros count as forward
	always_comb begin
		mag_next       = '0;
		mag_next.speed = up_data.speed;
		for (int w = 0; w < NUM_WHEELS; w++) begin
			mag_next.mag[w] = sin_q16(up_data.idx[w]);
			mag_next.fwd[w] = !(up_data.neg[w] && (mag_next.mag[w] != '0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			mag_s3 <= mag_next;
		end
	end

	assign dn_valid = valid_s3;
	assign dn_data  = mag_s3;

endmodule

`default_nettype wire

/* rtl/core/twom_scale.sv */
`default_nettype none

// Stage 4: scale speed by sine magnitude into the output register
module twom_scale (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 up_valid,
	output logic                      up_ready,
	input  wire twom_pkg::twom_mag_t  up_data,
	output logic                      dn_valid,
	input  wire logic                 dn_ready,
	output twom_pkg::twom_res_t       dn_data
);
	import twom_pkg::*;

	localparam int PROD_W = SPEED_W + MAG_W;

	logic               valid_s4;
	twom_res_t          res_s4;
	twom_res_t          res_next;
	logic [PROD_W-1:0]  prod [NUM_WHEELS];

	assign up_ready = !valid_s4 || dn_ready;

	// Keep the integer part of the Q16 product
	always_comb begin
		res_next = '0;
		for (int w = 0; w < NUM_WHEELS; w++) begin
			prod[w] = PROD_W'(up_data.speed) * PROD_W'(up_data.mag[w]);
			res_next.duty[w] = prod[w][FRAC_W +: DUTY_W];
			res_next.fwd[w]  = up_data.fwd[w];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (up_ready) begin
			valid_s4 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			res_s4 <= res_next;
		end
	end

	assign dn_valid = valid_s4;
	assign dn_data  = res_s4;

endmodule

`default_nettype wire
